// ----- rtl/slq_pkg.sv -----
// ----------------------------------------------------------------------------
// slq_pkg
// Shared types and constants of the sorted list queue: operation and status
// codes, sequencer states and the compare unit result.
// ----------------------------------------------------------------------------
package slq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int TAG_WIDTH_DEF = 16;

	typedef enum logic [2:0] {
		FN_INSERT    = 3'd0,
		FN_POP_FRONT = 3'd1,
		FN_POP_BACK  = 3'd2,
		FN_FIND      = 3'd3,
		FN_ERASE     = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BAD_POS   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_SCAN,
		S_SH_WR,
		S_INS_WR,
		S_FIND,
		S_RM_GET,
		S_RM_WR,
		S_PUSH
	} state_t;

	typedef struct packed {
		logic prec;
		logic eq;
	} cmp_t;

endpackage

// ----- rtl/slq_cmp.sv -----
// ----------------------------------------------------------------------------
// slq_cmp
// Shared key compare unit: order test for the selected direction and
// equality, used by the insert scan and the find scan.
// ----------------------------------------------------------------------------
module slq_cmp import slq_pkg::*; #(
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic [KEY_WIDTH-1:0] a,
	input  logic [KEY_WIDTH-1:0] b,
	input  logic                 descending,
	output cmp_t                 res
);

	logic lt;
	logic gt;

	assign lt       = (a < b);
	assign gt       = (a > b);
	assign res.prec = descending ? gt : lt;
	assign res.eq   = (a == b);

endmodule

// ----- rtl/sorted_list_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_list_queue_core
// Bounded sorted store of key and tag entries with insert, pop front,
// pop back, find and erase, run by a small sequencer over one entry memory.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries func, key_in, tag_in and
//    position_in. in_ready is high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready) returns one result per item:
//    status, key_out, tag_out, position_out, count_out, empty_out.
//  - Config channel (cfg_valid/cfg_ready/cfg_data) sets descending_order;
//    cfg_ready is always high. Write it only while the block is idle.
//  - Entries walk one per cycle through the entry memory, which has one
//    write port and one registered read port. Insert scans from the front
//    and then shifts entries up from the back, find scans from the front,
//    and pop and erase pull later entries down toward the front; error
//    cases go straight to the push state. in_ready rises together with
//    out_valid.
//  - If the receiver stalls, the finished result waits in the push state and
//    the block accepts nothing until the output register frees up.
//  - Reset empties the store (count zero) and selects ascending order; the
//    entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_list_queue_core import slq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int TAG_WIDTH = TAG_WIDTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           func,
	input  logic [KEY_WIDTH-1:0] key_in,
	input  logic [TAG_WIDTH-1:0] tag_in,
	input  logic [AW-1:0]        position_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [KEY_WIDTH-1:0] key_out,
	output logic [TAG_WIDTH-1:0] tag_out,
	output logic [AW-1:0]        position_out,
	output logic [CW-1:0]        count_out,
	output logic                 empty_out,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);

	state_t               state_q, state_d;
	func_t                func_q, func_d;
	logic [KEY_WIDTH-1:0] key_q, key_d;
	logic [TAG_WIDTH-1:0] tag_q, tag_d;
	logic [AW-1:0]        idx_q, idx_d;
	logic [AW-1:0]        pos_q, pos_d;
	logic [CW-1:0]        count_q, count_d;
	logic                 desc_q;

	status_t              res_status_q, res_status_d;
	logic [KEY_WIDTH-1:0] res_key_q, res_key_d;
	logic [TAG_WIDTH-1:0] res_tag_q, res_tag_d;
	logic [AW-1:0]        res_pos_q, res_pos_d;

	logic                 out_valid_q, out_valid_d;
	logic                 out_load;
	status_t              out_status_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic [TAG_WIDTH-1:0] out_tag_q;
	logic [AW-1:0]        out_pos_q;
	logic [CW-1:0]        out_count_q;

	logic [KEY_WIDTH-1:0] key_mem [DEPTH];
	logic [TAG_WIDTH-1:0] tag_mem [DEPTH];
	logic [KEY_WIDTH-1:0] rd_key_q;
	logic [TAG_WIDTH-1:0] rd_tag_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [AW-1:0]        mem_raddr;
	logic [KEY_WIDTH-1:0] mem_wkey;
	logic [TAG_WIDTH-1:0] mem_wtag;

	logic                 in_fire;
	func_t                in_func;
	cmp_t                 cmp;
	logic [CW-1:0]        cnt_m1;
	logic [AW-1:0]        last_idx;
	logic [AW-1:0]        idx_p1;
	logic [AW-1:0]        idx_p2;
	logic [AW-1:0]        idx_m1;
	logic [AW-1:0]        pos_p1;
	logic                 idx_is_last;

	assign in_func     = func_t'(func);
	assign in_ready    = (state_q == S_IDLE);
	assign in_fire     = in_valid & in_ready;
	assign cfg_ready   = 1'b1;
	assign cnt_m1      = count_q - CW'(1);
	assign last_idx    = cnt_m1[AW-1:0];
	assign idx_p1      = idx_q + AW'(1);
	assign idx_p2      = idx_q + AW'(2);
	assign idx_m1      = idx_q - AW'(1);
	assign pos_p1      = pos_q + AW'(1);
	assign idx_is_last = (CW'(idx_q) == cnt_m1);

	slq_cmp #(
		.KEY_WIDTH(KEY_WIDTH)
	) u_cmp (
		.a          (key_q),
		.b          (rd_key_q),
		.descending (desc_q),
		.res        (cmp)
	);

	// entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr] <= mem_wkey;
			tag_mem[mem_waddr] <= mem_wtag;
		end
		rd_key_q <= key_mem[mem_raddr];
		rd_tag_q <= tag_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			desc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				desc_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q       <= func_d;
		key_q        <= key_d;
		tag_q        <= tag_d;
		idx_q        <= idx_d;
		pos_q        <= pos_d;
		res_status_q <= res_status_d;
		res_key_q    <= res_key_d;
		res_tag_q    <= res_tag_d;
		res_pos_q    <= res_pos_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_tag_q    <= res_tag_q;
			out_pos_q    <= res_pos_q;
			out_count_q  <= count_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		func_d       = func_q;
		key_d        = key_q;
		tag_d        = tag_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		count_d      = count_q;
		res_status_d = res_status_q;
		res_key_d    = res_key_q;
		res_tag_d    = res_tag_q;
		res_pos_d    = res_pos_q;
		out_valid_d  = out_valid_q & ~out_ready;
		out_load     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = idx_q;
		mem_wkey     = rd_key_q;
		mem_wtag     = rd_tag_q;
		mem_raddr    = idx_q;

		case (state_q)
			S_IDLE: begin
				// issue the first read so the entry is ready in the next state
				case (in_func)
					FN_POP_BACK: mem_raddr = last_idx;
					FN_ERASE:    mem_raddr = position_in;
					default:     mem_raddr = '0;
				endcase
				if (in_fire) begin
					func_d       = in_func;
					key_d        = key_in;
					tag_d        = tag_in;
					idx_d        = '0;
					res_status_d = ST_OK;
					res_key_d    = '0;
					res_tag_d    = '0;
					res_pos_d    = '0;
					state_d      = S_PUSH;
					case (in_func)
						FN_INSERT: begin
							if (count_q == CW'(DEPTH)) begin
								res_status_d = ST_FULL;
							end else if (count_q == '0) begin
								pos_d   = '0;
								state_d = S_INS_WR;
							end else begin
								state_d = S_INS_SCAN;
							end
						end
						FN_POP_FRONT, FN_POP_BACK: begin
							if (count_q == '0) begin
								res_status_d = ST_EMPTY;
							end else begin
								pos_d   = (in_func == FN_POP_FRONT) ? '0 : last_idx;
								state_d = S_RM_GET;
							end
						end
						FN_FIND: begin
							if (count_q == '0) begin
								res_status_d = ST_NOT_FOUND;
							end else begin
								state_d = S_FIND;
							end
						end
						FN_ERASE: begin
							if (CW'(position_in) >= count_q) begin
								res_status_d = ST_BAD_POS;
							end else begin
								pos_d   = position_in;
								state_d = S_RM_GET;
							end
						end
						default: begin
							state_d = S_PUSH;
						end
					endcase
				end
			end

			S_INS_SCAN: begin
				if (cmp.prec) begin
					// open a slot: move entries up from the back
					pos_d     = idx_q;
					idx_d     = last_idx;
					mem_raddr = last_idx;
					state_d   = S_SH_WR;
				end else if (idx_is_last) begin
					pos_d   = count_q[AW-1:0];
					state_d = S_INS_WR;
				end else begin
					idx_d     = idx_p1;
					mem_raddr = idx_p1;
				end
			end

			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_p1;
				if (idx_q == pos_q) begin
					state_d = S_INS_WR;
				end else begin
					idx_d     = idx_m1;
					mem_raddr = idx_m1;
				end
			end

			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wkey  = key_q;
				mem_wtag  = tag_q;
				count_d   = count_q + CW'(1);
				res_pos_d = pos_q;
				state_d   = S_PUSH;
			end

			S_FIND: begin
				if (cmp.eq) begin
					res_pos_d = idx_q;
					state_d   = S_PUSH;
				end else if (idx_is_last) begin
					res_status_d = ST_NOT_FOUND;
					state_d      = S_PUSH;
				end else begin
					idx_d     = idx_p1;
					mem_raddr = idx_p1;
				end
			end

			S_RM_GET: begin
				res_key_d = rd_key_q;
				res_tag_d = rd_tag_q;
				if (CW'(pos_q) == cnt_m1) begin
					count_d = cnt_m1;
					state_d = S_PUSH;
				end else begin
					// close the gap: pull entries down toward the front
					idx_d     = pos_q;
					mem_raddr = pos_p1;
					state_d   = S_RM_WR;
				end
			end

			S_RM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				if ((CW'(idx_q) + CW'(2)) == count_q) begin
					count_d = cnt_m1;
					state_d = S_PUSH;
				end else begin
					idx_d     = idx_p1;
					mem_raddr = idx_p2;
				end
			end

			S_PUSH: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign key_out      = out_key_q;
	assign tag_out      = out_tag_q;
	assign position_out = out_pos_q;
	assign count_out    = out_count_q;
	assign empty_out    = (out_count_q == '0);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("ready right after an input transfer");

	a_write_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != S_IDLE) && (state_q != S_PUSH))
		else $error("memory write outside an operation");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_FULL)) |-> (out_count_q == CW'(DEPTH)))
		else $error("full status with store not full");

endmodule
